>>> hdl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Request and response types, request and status codes, and the
// find-first-set helper that the allocator uses.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int WORD_BITS = 32;
  localparam int RC_W      = 13;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_FREE  = 3'd1;
  localparam logic [2:0] REQ_MARK  = 3'd2;
  localparam logic [2:0] REQ_INIT  = 3'd3;
  localparam logic [2:0] REQ_LOAD  = 3'd4;
  localparam logic [2:0] REQ_READ  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [0:0] REG_RESERVED_COUNT = 1'b0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] index;
    logic [31:0] word_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] alloc_index;
    logic [31:0] read_word;
  } resp_t;

  // Position of the lowest set bit; zero when no bit is set.
  function automatic logic [4:0] ffs32(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/bba_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator configuration registers
// APB-style register port holding the reserved entry count used by init.
// ----------------------------------------------------------------------------
module bba_apb
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [RC_W-1:0]   reserved_count
);

  logic reg_sel;

  // Registers sit on 32-bit boundaries, so the low two address bits are ignored.
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_RESERVED_COUNT);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_count <= RC_W'(4);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      reserved_count <= pwdata[RC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = DATA_W'(reserved_count);
    end
  end

endmodule

>>> hdl/bba_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// Free map and per-word summary memories with the request sequencer.
// ----------------------------------------------------------------------------
module bba_core
  import bba_pkg::*;
#(
  parameter int NUM_ENTRIES = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  req_t            req,
  output logic            done,
  output resp_t           resp,
  input  logic [RC_W-1:0] reserved_count
);

  localparam int NUM_WORDS = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int NC        = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int CW        = (NC > 1) ? $clog2(NC) : 1;
  localparam int NUM_REM   = NUM_ENTRIES % WORD_BITS;
  localparam int NSW_RAW   = $clog2(NUM_ENTRIES + 1);
  localparam int NSW       = (NSW_RAW > RC_W) ? NSW_RAW : RC_W;
  localparam logic [WW-1:0] LAST_W = WW'(NUM_WORDS - 1);
  localparam logic [CW-1:0] LAST_C = CW'(NC - 1);
  localparam logic [31:0] LAST_MASK =
    (NUM_REM == 0) ? 32'hFFFF_FFFF : ((32'd1 << NUM_REM) - 32'd1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_RMW   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;

  function automatic logic [CW-1:0] chunk_of(input logic [WW-1:0] w);
    return CW'(32'(w) >> 5);
  endfunction

  function automatic logic [31:0] mask_of(input logic [WW-1:0] w);
    return (w == LAST_W) ? LAST_MASK : 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] put_bit(input logic [31:0] v, input logic [4:0] p,
                                          input logic b);
    return (v & ~(32'd1 << p)) | (32'(b) << p);
  endfunction

  // Memories: the free map and a summary holding one "has a free entry" bit per map word.
  logic [31:0] map_mem [NUM_WORDS];
  logic [31:0] sum_mem [NC];
  logic [31:0] map_q, sum_q;
  logic [WW-1:0] map_raddr, map_waddr;
  logic [CW-1:0] sum_raddr, sum_waddr;
  logic [31:0] map_wdata, sum_wdata;
  logic map_we, sum_we;

  logic [2:0]    state, state_next;
  logic [WW-1:0] wcnt, wcnt_next;
  logic [CW-1:0] chunk, chunk_next;
  logic [WW-1:0] word_r, word_next;
  logic [4:0]    bit_r, bit_next;
  logic [2:0]    op_r, op_next;
  logic [31:0]   data_r, data_next;
  logic [31:0]   sum_hold, sum_hold_next;
  logic [31:0]   acc, acc_next;
  logic [WW:0]   nw_r, nw_next;
  logic [4:0]    nr_r, nr_next;
  logic          init_r, init_next;
  logic          done_next;
  resp_t         res_next;

  logic [WW-1:0] in_word;
  logic          entry_oor, word_oor;
  logic [NSW-1:0] rc_ext, n_sat;
  logic [4:0]    fb, sb;
  logic [31:0]   new_word, sw_val, acc_base;
  logic          nb;
  logic [WW-1:0] found_word;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_q <= sum_mem[sum_raddr];
  end

  assign busy      = (state != S_IDLE);
  assign entry_oor = (32'(req.index) >= NUM_ENTRIES);
  assign word_oor  = (32'(req.index) >= NUM_WORDS);
  assign in_word   = ((req.req_type == REQ_LOAD) || (req.req_type == REQ_READ)) ?
                     WW'(req.index) : WW'(32'(req.index) >> 5);
  assign rc_ext    = NSW'(reserved_count);
  assign n_sat     = (rc_ext > NSW'(NUM_ENTRIES)) ? NSW'(NUM_ENTRIES) : rc_ext;
  assign sb         = ffs32(sum_q);
  assign found_word = WW'({chunk, sb});
  assign fb         = ffs32(map_q & mask_of(word_r));

  always_comb begin
    state_next    = state;
    wcnt_next     = wcnt;
    chunk_next    = chunk;
    word_next     = word_r;
    bit_next      = bit_r;
    op_next       = op_r;
    data_next     = data_r;
    sum_hold_next = sum_hold;
    acc_next      = acc;
    nw_next       = nw_r;
    nr_next       = nr_r;
    init_next     = init_r;
    done_next     = 1'b0;
    res_next      = '0;
    map_raddr     = word_r;
    sum_raddr     = chunk;
    map_we        = 1'b0;
    map_waddr     = word_r;
    map_wdata     = map_q;
    sum_we        = 1'b0;
    sum_waddr     = chunk_of(word_r);
    sum_wdata     = sum_q;
    new_word      = map_q;
    nb            = 1'b0;
    sw_val        = 32'hFFFF_FFFF;
    acc_base      = acc;

    case (state)
      S_IDLE: begin
        map_raddr = in_word;
        sum_raddr = chunk_of(in_word);
        if (start) begin
          op_next   = req.req_type;
          word_next = in_word;
          bit_next  = req.index[4:0];
          data_next = req.word_data;
          case (req.req_type)
            REQ_ALLOC: begin
              chunk_next = '0;
              sum_raddr  = '0;
              state_next = S_SCAN;
            end
            REQ_FREE, REQ_MARK: begin
              if (entry_oor) begin
                done_next       = 1'b1;
                res_next.status = ST_RANGE;
              end else begin
                state_next = S_RMW;
              end
            end
            REQ_INIT: begin
              init_next  = 1'b1;
              nw_next    = (WW + 1)'(n_sat >> 5);
              nr_next    = n_sat[4:0];
              wcnt_next  = '0;
              state_next = S_SWEEP;
            end
            REQ_LOAD: begin
              if (word_oor) begin
                done_next       = 1'b1;
                res_next.status = ST_RANGE;
              end else begin
                state_next = S_RMW;
              end
            end
            REQ_READ: begin
              if (word_oor) begin
                done_next       = 1'b1;
                res_next.status = ST_RANGE;
              end else begin
                state_next = S_RD;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (sum_q != 32'd0) begin
          word_next     = found_word;
          map_raddr     = found_word;
          sum_hold_next = sum_q;
          state_next    = S_FIND;
        end else if (chunk == LAST_C) begin
          done_next       = 1'b1;
          res_next.status = ST_FULL;
          state_next      = S_IDLE;
        end else begin
          chunk_next = chunk + CW'(1);
          sum_raddr  = chunk + CW'(1);
        end
      end

      S_FIND: begin
        new_word  = map_q & ~(32'd1 << fb);
        nb        = |(new_word & mask_of(word_r));
        map_we    = 1'b1;
        map_wdata = new_word;
        sum_we    = 1'b1;
        sum_wdata = put_bit(sum_hold, 5'(word_r), nb);
        done_next = 1'b1;
        res_next.alloc_index = 12'({word_r, fb});
        state_next = S_IDLE;
      end

      S_RMW: begin
        case (op_r)
          REQ_FREE: new_word = map_q | (32'd1 << bit_r);
          REQ_MARK: new_word = map_q & ~(32'd1 << bit_r);
          default:  new_word = data_r;
        endcase
        nb         = |(new_word & mask_of(word_r));
        map_we     = 1'b1;
        map_wdata  = new_word;
        sum_we     = 1'b1;
        sum_wdata  = put_bit(sum_q, 5'(word_r), nb);
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_RD: begin
        done_next          = 1'b1;
        res_next.read_word = map_q;
        state_next         = S_IDLE;
      end

      S_SWEEP: begin
        // Words wholly below the reserved count are all used, the word holding
        // the boundary is partly used, and everything above is free.
        if ({1'b0, wcnt} < nw_r) begin
          sw_val = 32'd0;
        end else if ({1'b0, wcnt} == nw_r) begin
          sw_val = 32'hFFFF_FFFF << nr_r;
        end else begin
          sw_val = 32'hFFFF_FFFF;
        end
        nb        = |(sw_val & mask_of(wcnt));
        acc_base  = (5'(wcnt) == 5'd0) ? 32'd0 : acc;
        acc_next  = acc_base | (32'(nb) << 5'(wcnt));
        map_we    = 1'b1;
        map_waddr = wcnt;
        map_wdata = sw_val;
        sum_waddr = chunk_of(wcnt);
        sum_wdata = acc_next;
        sum_we    = (5'(wcnt) == 5'd31) || (wcnt == LAST_W);
        if (wcnt == LAST_W) begin
          done_next  = init_r;
          state_next = S_IDLE;
        end else begin
          wcnt_next = wcnt + WW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      wcnt   <= '0;
      chunk  <= '0;
      nw_r   <= '0;
      nr_r   <= '0;
      init_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      wcnt   <= wcnt_next;
      chunk  <= chunk_next;
      nw_r   <= nw_next;
      nr_r   <= nr_next;
      init_r <= init_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_next;
    bit_r    <= bit_next;
    op_r     <= op_next;
    data_r   <= data_next;
    sum_hold <= sum_hold_next;
    acc      <= acc_next;
    resp     <= res_next;
  end

endmodule

>>> hdl/bitmap_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a free bitmap of NUM_ENTRIES entries, with an
// APB-style register for the count of entries reserved by init.
// ----------------------------------------------------------------------------
// One request is handled at a time; busy is high while it is in progress and
// every request produces exactly one result beat, shown on resp for the single
// cycle in which done is high. The receiver cannot stall, so results must be
// taken as they appear. Unknown and out-of-range requests are answered without
// leaving the idle state; free, mark used and load word read the map word and
// write it back; read word reads the map word; allocate scans the summary one
// group of 32 map words at a time, passing over groups with no free entry,
// then reads the map word that it found and writes it back, and reports a full
// map once the last group is found empty; init rewrites the map one word per
// cycle. The map and summary memories each have a single read port. After
// reset the same sweep clears the map to all free, holding busy high while it
// runs; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int NUM_ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output resp_t             resp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [RC_W-1:0] reserved_count;

  bba_apb u_apb (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .reserved_count (reserved_count)
  );

  bba_core #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req            (req),
    .done           (done),
    .resp           (resp),
    .reserved_count (reserved_count)
  );

endmodule

>>> hdl/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  start,
  input logic  busy,
  input logic  done,
  input resp_t resp,
  input logic  pready
);

  // An accepted request either completes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request neither completed nor held busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (resp.status == ST_OK) || (resp.status == ST_FULL) ||
             (resp.status == ST_RANGE))
    else $error("result carries an undefined status");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    done && (resp.status != ST_OK) |-> (resp.alloc_index == 12'd0) &&
                                       (resp.read_word == 32'd0))
    else $error("failed request returned data");

  a_one_payload: assert property (@(posedge clk) disable iff (rst)
    done && (resp.read_word != 32'd0) |-> (resp.alloc_index == 12'd0))
    else $error("result carries both an entry and a map word");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("register port inserted a wait state");

endmodule

bind bitmap_block_allocator_top bba_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .resp   (resp),
  .pready (pready)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate, free, mark-used, init, word load and word read requests
// through the start/busy port and programs the reserved count over the
// register port. Every result beat is checked field by field: in the leading
// directed list against results typed in by hand, in the randomised phases
// (each with its own reserved count) against a first-fit free map alongside.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  localparam int N_ENTRIES   = 4096;
  localparam int MAP_WORDS   = N_ENTRIES / WORD_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 100;

  // Request codes that the block must treat as no-ops.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  localparam logic [ADDR_W-1:0] RC_ADDR = {REG_RESERVED_COUNT, 2'b00};

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  logic              busy;
  req_t              req_in  = '0;
  logic              done;
  resp_t             resp_out;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bitmap_block_allocator_top #(
    .NUM_ENTRIES(N_ENTRIES)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req_in),
    .done   (done),
    .resp   (resp_out),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator state.
  logic [WORD_BITS-1:0] free_map_q [MAP_WORDS];
  logic [RC_W-1:0]      rsv_count;

  resp_t       pending[$];
  logic [11:0] handed_out[$];

  // A directed row may carry a result typed in by hand.
  bit    typed_valid = 1'b0;
  resp_t typed_resp  = '0;
  bit    idle_on     = 1'b1;

  int n_fail      = 0;
  int n_items     = 0;
  int n_full      = 0;
  int n_range     = 0;
  int n_cfg       = 0;
  int cycle_count = 0;
  int cnt_type [8];

  typedef struct {
    bit              is_cfg;
    logic [RC_W-1:0] cfg_val;
    req_t            rq;
    bit              typed;
    resp_t           want;
  } step_t;

  step_t plan[$];

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) begin
      free_map_q[w] = '1;
    end
    rsv_count = RC_W'(4);
    for (int t = 0; t < 8; t++) begin
      cnt_type[t] = 0;
    end
  end

  function automatic resp_t apply_request(input req_t r);
    resp_t o;
    bit    hit;
    int    lim;
    o   = '0;
    hit = 1'b0;
    case (r.req_type)
      REQ_ALLOC: begin
        for (int w = 0; w < MAP_WORDS && !hit; w++) begin
          if (free_map_q[w] != '0) begin
            for (int b = 0; b < WORD_BITS && !hit; b++) begin
              if (free_map_q[w][b] && (w * WORD_BITS + b) < N_ENTRIES) begin
                hit              = 1'b1;
                free_map_q[w][b] = 1'b0;
                o.alloc_index    = 12'(w * WORD_BITS + b);
              end
            end
          end
        end
        if (!hit) begin
          o.status = ST_FULL;
        end
      end
      REQ_FREE, REQ_MARK: begin
        if (int'(r.index) >= N_ENTRIES) begin
          o.status = ST_RANGE;
        end else begin
          free_map_q[r.index / WORD_BITS][r.index % WORD_BITS] = (r.req_type == REQ_FREE);
        end
      end
      REQ_INIT: begin
        for (int w = 0; w < MAP_WORDS; w++) begin
          free_map_q[w] = '1;
        end
        lim = (int'(rsv_count) > N_ENTRIES) ? N_ENTRIES : int'(rsv_count);
        for (int e = 0; e < lim; e++) begin
          free_map_q[e / WORD_BITS][e % WORD_BITS] = 1'b0;
        end
      end
      REQ_LOAD, REQ_READ: begin
        if (int'(r.index) >= MAP_WORDS) begin
          o.status = ST_RANGE;
        end else if (r.req_type == REQ_LOAD) begin
          free_map_q[r.index] = r.word_data;
        end else begin
          o.read_word = free_map_q[r.index];
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Results are checked before the request accepted at the same edge is
  // predicted, so the queue always holds them in order.
  always @(posedge clk) begin : result_check
    resp_t want;
    resp_t got;
    if (!rst) begin
      if (done) begin
        got = resp_out;
        if (pending.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d alloc_index %0d",
                 got.status, got.alloc_index);
          n_fail++;
        end else begin
          want = pending.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_fail++;
          end
          if (got.alloc_index !== want.alloc_index) begin
            $error("alloc_index: expected %0d, got %0d", want.alloc_index, got.alloc_index);
            n_fail++;
          end
          if (got.read_word !== want.read_word) begin
            $error("read_word: expected %h, got %h", want.read_word, got.read_word);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_request(req_in);
        if (want.status == ST_FULL) begin
          n_full++;
        end
        if (want.status == ST_RANGE) begin
          n_range++;
        end
        if (req_in.req_type == REQ_ALLOC && want.status == ST_OK) begin
          handed_out.push_back(want.alloc_index);
        end
        pending.push_back(typed_valid ? typed_resp : want);
        cnt_type[req_in.req_type]++;
        n_items++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bitmap_block_allocator_top] ERROR");
      $finish;
    end
  end

  task automatic issue(input req_t r, input bit typed, input resp_t want);
    @(negedge clk);
    start       <= 1'b1;
    req_in      <= r;
    typed_valid = typed;
    typed_resp  = want;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 99) < 10) begin
      pause_sender($urandom_range(1, 8));
    end
  endtask

  // Holds the sender off until every outstanding result has been seen.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(input logic [ADDR_W-1:0] a, output logic [DATA_W-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reserved();
    logic [DATA_W-1:0] rd;
    reg_read(RC_ADDR, rd);
    if (rd !== DATA_W'(rsv_count)) begin
      $error("reserved_count: expected %0d, got %0d", rsv_count, rd);
      n_fail++;
    end
  endtask

  task automatic program_reserved(input logic [RC_W-1:0] v);
    settle();
    reg_write(RC_ADDR, DATA_W'(v));
    rsv_count = v;
    n_cfg++;
    check_reserved();
  endtask

  function automatic void add_req(input logic [2:0] t, input logic [11:0] i,
                                  input logic [31:0] d, input bit typed = 1'b0,
                                  input logic [1:0] st = ST_OK,
                                  input logic [11:0] ai = '0,
                                  input logic [31:0] rw = '0);
    step_t s;
    s.is_cfg            = 1'b0;
    s.cfg_val           = '0;
    s.rq.req_type       = t;
    s.rq.index          = i;
    s.rq.word_data      = d;
    s.typed             = typed;
    s.want.status       = st;
    s.want.alloc_index  = ai;
    s.want.read_word    = rw;
    plan.push_back(s);
  endfunction

  function automatic void add_cfg(input logic [RC_W-1:0] v);
    step_t s;
    s        = '{default: '0};
    s.is_cfg = 1'b1;
    s.cfg_val = v;
    plan.push_back(s);
  endfunction

  function automatic req_t random_request(input bit tight);
    req_t r;
    int   roll;
    int   pos;
    r.index     = 12'($urandom_range(0, 4095));
    r.word_data = $urandom;
    roll        = $urandom_range(0, 99);
    if (roll < 40) begin
      r.req_type = REQ_ALLOC;
    end else if (roll < 55) begin
      r.req_type = REQ_FREE;
      // Mostly give back something that was handed out earlier.
      if (handed_out.size() > 0 && $urandom_range(0, 9) < 7) begin
        pos     = $urandom_range(0, handed_out.size() - 1);
        r.index = handed_out[pos];
        handed_out.delete(pos);
      end
    end else if (roll < 63) begin
      r.req_type = REQ_MARK;
      if ($urandom_range(0, 1) == 1) begin
        r.index = 12'($urandom_range(0, 63));
      end
    end else if (roll < 65) begin
      r.req_type = REQ_INIT;
    end else if (roll < 95) begin
      r.req_type = (roll < 77) ? REQ_LOAD : REQ_READ;
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        r.index = 12'($urandom_range(0, 7));
      end else if (roll < 8) begin
        r.index = 12'($urandom_range(0, MAP_WORDS - 1));
      end else begin
        r.index = 12'($urandom_range(MAP_WORDS, 4095));
      end
      // With a nearly full map, loads mostly keep it full.
      if (tight && $urandom_range(0, 3) != 0) begin
        r.word_data = '0;
      end else begin
        case ($urandom_range(0, 3))
          0: r.word_data = '0;
          1: r.word_data = '1;
          2: r.word_data = 32'd1 << $urandom_range(0, 31);
          default: begin
          end
        endcase
      end
    end else begin
      r.req_type = ($urandom_range(0, 1) == 1) ? REQ_SPARE_A : REQ_SPARE_B;
    end
    return r;
  endfunction

  initial begin
    logic [RC_W-1:0] phase_rc [N_PHASES];
    step_t           s;
    req_t            r;

    // After reset the map is all free, but init has not yet run.
    add_req(REQ_READ,  12'd0,    '0,              1'b1, ST_OK,    12'd0,    32'hFFFF_FFFF);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd0);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd1);
    add_req(REQ_READ,  12'd127,  '0,              1'b1, ST_OK,    12'd0,    32'hFFFF_FFFF);
    add_req(REQ_READ,  12'd128,  '0,              1'b1, ST_RANGE);
    add_req(REQ_LOAD,  12'd4095, 32'hFFFF_FFFF,   1'b1, ST_RANGE);
    add_req(REQ_INIT,  12'd0,    '0,              1'b1, ST_OK);
    add_req(REQ_READ,  12'd0,    '0,              1'b1, ST_OK,    12'd0,    32'hFFFF_FFF0);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd4);
    add_req(REQ_FREE,  12'd0,    '0,              1'b1, ST_OK);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd0);
    add_req(REQ_MARK,  12'd4095, '0,              1'b1, ST_OK);
    add_req(REQ_READ,  12'd127,  '0,              1'b1, ST_OK,    12'd0,    32'h7FFF_FFFF);
    add_req(REQ_LOAD,  12'd0,    32'h0000_0000,   1'b1, ST_OK);
    add_req(REQ_LOAD,  12'd1,    32'h8000_0000,   1'b1, ST_OK);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd63);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd64);
    add_req(REQ_SPARE_A, 12'hFFF, 32'hFFFF_FFFF,  1'b1, ST_OK);
    add_req(REQ_SPARE_B, 12'd0,  '0,              1'b1, ST_OK);
    // A reserved count beyond the map size fills the whole map.
    add_cfg(RC_W'(8191));
    add_req(REQ_INIT,  12'd0,    '0,              1'b1, ST_OK);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_FULL);
    add_req(REQ_READ,  12'd127,  '0,              1'b1, ST_OK,    12'd0,    32'h0);
    add_req(REQ_FREE,  12'd4095, '0,              1'b1, ST_OK);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd4095);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_FULL);
    add_cfg(RC_W'(0));
    add_req(REQ_INIT,  12'd0,    '0,              1'b1, ST_OK);
    add_req(REQ_ALLOC, 12'd0,    '0,              1'b1, ST_OK,    12'd0);

    phase_rc[0] = RC_W'(4);
    phase_rc[1] = RC_W'(0);
    phase_rc[2] = RC_W'(4095);
    phase_rc[3] = RC_W'(8191);
    phase_rc[4] = RC_W'(4064);
    phase_rc[5] = RC_W'(33);
    phase_rc[6] = RC_W'($urandom_range(0, 8191));
    phase_rc[7] = RC_W'(4000 + $urandom_range(0, 96));

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    check_reserved();

    foreach (plan[n]) begin
      s = plan[n];
      if (s.is_cfg) begin
        program_reserved(s.cfg_val);
      end else begin
        maybe_idle();
        issue(s.rq, s.typed, s.want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      program_reserved(phase_rc[ph]);
      idle_on = (ph != 1);
      r = '0;
      r.req_type = REQ_INIT;
      issue(r, 1'b0, '0);
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          settle();
        end
        maybe_idle();
        issue(random_request(int'(phase_rc[ph]) >= 4000), 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d requests: %0d allocate, %0d free, %0d mark used, %0d init, %0d load,",
             n_items, cnt_type[REQ_ALLOC], cnt_type[REQ_FREE], cnt_type[REQ_MARK],
             cnt_type[REQ_INIT], cnt_type[REQ_LOAD]);
    $display("%0d read, %0d no-op; %0d map-full, %0d out-of-range; %0d register writes.",
             cnt_type[REQ_READ], cnt_type[REQ_SPARE_A] + cnt_type[REQ_SPARE_B],
             n_full, n_range, n_cfg);
    if (n_fail == 0) begin
      $display("[bitmap_block_allocator_top] OK");
    end else begin
      $display("[bitmap_block_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
